// ===== sv/rpn_pkg.sv =====
package rpn_pkg;

    // Data path width and the default stack size.
    localparam int DATA_W        = 32;
    localparam int STACK_DEF     = 16;
    localparam int CHAR_W        = 8;
    localparam int DEPTH_OUT_W   = 5;
    localparam int STATUS_W      = 3;
    localparam int RES_W         = DATA_W + DEPTH_OUT_W + STATUS_W;

    // Character codes of the expression alphabet.
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MUL  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_ADD  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DIV  = 8'h2F;

    // Status codes reported with each result.
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd4;

    // Class of one character after decoding.
    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_MUL  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_DIV  = 3'd4,
        OP_BAD  = 3'd5
    } op_kind_t;

    // One decoded request as it sits in the queue.
    typedef struct packed {
        op_kind_t    kind;
        logic [3:0]  digit;
        logic        last;
    } item_t;

    // Status of the execution side, watched at the top level.
    typedef struct packed {
        logic over;
        logic err_set;
        logic emit;
    } back_stat_t;

endpackage

// ===== sv/rpn_ram.sv =====
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rpn_div.sv =====
module rpn_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rpn_pkg::DATA_W-1:0] dividend,
    input  logic [rpn_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [rpn_pkg::DATA_W-1:0] quotient
);
    import rpn_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic [DATA_W:0]   part;
    logic [DATA_W:0]   diff;

    // One restoring step per cycle on the magnitudes.
    assign part = {rem_reg, quo_reg[DATA_W-1]};
    assign diff = part - {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            neg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rem_next = '0;
            quo_next = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            den_next = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
        end
        else if (run_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = part[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    // Restore the sign; the most negative over minus one wraps by itself.
    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

// ===== sv/rpn_front.sv =====
module rpn_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [rpn_pkg::CHAR_W-1:0] s_axis_tdata,
    input  logic                      s_axis_tlast,
    output logic                      q_valid,
    output rpn_pkg::item_t            q_item,
    input  logic                      q_pop
);
    import rpn_pkg::*;

    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    item_t       slot_reg [2];
    item_t       dec;
    logic        push;

    // Decode the incoming character.
    always_comb
    begin
        dec.last  = s_axis_tlast;
        dec.digit = 4'(s_axis_tdata - CH_ZERO);
        if (s_axis_tdata >= CH_ZERO && s_axis_tdata <= CH_NINE)
        begin
            dec.kind = OP_PUSH;
        end
        else
        begin
            case (s_axis_tdata)
                CH_MUL:  dec.kind = OP_MUL;
                CH_ADD:  dec.kind = OP_ADD;
                CH_SUB:  dec.kind = OP_SUB;
                CH_DIV:  dec.kind = OP_DIV;
                default: dec.kind = OP_BAD;
            endcase
        end
    end

    // Two-entry queue toward the execution side.
    assign s_axis_tready = (cnt_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (cnt_reg != 2'd0);
    assign q_item        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== sv/rpn_back.sv =====
module rpn_back #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  rpn_pkg::item_t           q_item,
    output logic                     q_pop,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [rpn_pkg::RES_W-1:0] m_axis_tdata,
    output rpn_pkg::back_stat_t      stat
);
    import rpn_pkg::*;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_OPER = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic                last_reg, last_next;
    op_kind_t            kind_reg, kind_next;
    logic [DATA_W-1:0]   top_reg, top_next;
    logic                out_valid_reg, out_valid_next;
    logic [RES_W-1:0]    out_data_reg, out_data_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   lhs;
    logic [DATA_W-1:0]   prod;
    logic                div_start;
    logic                div_done;
    logic [DATA_W-1:0]   div_q;
    logic                out_free;

    // Entries below the top of stack; the top itself lives in top_reg.
    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (lhs)
    );

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lhs),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign ram_waddr = AW'(sp_reg - SP_W'(1));
    assign ram_raddr = AW'(sp_reg - SP_W'(2));
    assign prod      = lhs * top_reg;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    // Sequencer: take a request, execute it, report on the last character.
    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        kind_next      = kind_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        div_start      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    last_next  = q_item.last;
                    kind_next  = q_item.kind;
                    state_next = q_item.last ? S_EMIT : S_IDLE;
                    if (err_reg == ST_OK)
                    begin
                        unique case (q_item.kind) inside
                            OP_PUSH:
                            begin
                                if (sp_reg == SP_W'(STACK_DEPTH))
                                begin
                                    err_next = ST_OVER;
                                end
                                else
                                begin
                                    ram_we   = (sp_reg != '0);
                                    top_next = DATA_W'(q_item.digit);
                                    sp_next  = sp_reg + 1'b1;
                                end
                            end
                            OP_MUL, OP_ADD, OP_SUB, OP_DIV:
                            begin
                                if (sp_reg < SP_W'(2))
                                begin
                                    err_next = ST_UNDER;
                                end
                                else
                                begin
                                    state_next = S_OPER;
                                end
                            end
                            default:
                            begin
                                err_next = ST_BAD;
                            end
                        endcase
                    end
                end
            end
            S_OPER:
            begin
                state_next = last_reg ? S_EMIT : S_IDLE;
                case (kind_reg)
                    OP_MUL:
                    begin
                        top_next = prod;
                        sp_next  = sp_reg - 1'b1;
                    end
                    OP_ADD:
                    begin
                        top_next = lhs + top_reg;
                        sp_next  = sp_reg - 1'b1;
                    end
                    OP_SUB:
                    begin
                        top_next = lhs - top_reg;
                        sp_next  = sp_reg - 1'b1;
                    end
                    default:
                    begin
                        if (top_reg == '0)
                        begin
                            err_next = ST_DIVZ;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    top_next   = div_q;
                    sp_next    = sp_reg - 1'b1;
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {err_reg, DEPTH_OUT_W'(sp_reg),
                                      (sp_reg != '0) ? top_reg : DATA_W'(0)};
                    sp_next        = '0;
                    err_next       = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        top_reg      <= top_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign stat.over    = (sp_reg > SP_W'(STACK_DEPTH));
    assign stat.err_set = (err_reg != ST_OK);
    assign stat.emit    = (state_reg == S_EMIT) && out_free;

endmodule

// ===== sv/postfix_expression_evaluator.sv =====
// Postfix expression evaluator. Characters arrive one per request on the
// input stream; digits push 0..9, and * + - / pop two values and push the
// 32-bit wrapping result (left operand is the one below the top, quotient
// truncates toward zero). The first bad character, underflow, overflow or
// divide by zero is latched and later characters are ignored. The request
// marked tlast produces one result (top value or 0, depth, status) and then
// clears the stack. Digits and bad characters end in the idle state, + - *
// in the operate state, / in the divide state on the one-bit-per-cycle
// divider; a tlast request loads the result register. A two-entry queue
// decouples the input side; the result register lets work go on while it waits.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] top_value, [36:32] stack_depth,
                                        // [39:37] status
);
    import rpn_pkg::*;

    logic       q_valid;
    item_t      q_item;
    logic       q_pop;
    back_stat_t bk_stat;

    rpn_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    rpn_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .stat          (bk_stat)
    );

`ifndef SYNTHESIS
    // The execution side only takes a request that the queue holds.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // The stack pointer never passes the stack size.
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        !bk_stat.over)
        else $error("stack pointer beyond stack size");

    // Loading a result presents it on the output.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.emit |=> m_axis_tvalid)
        else $error("result not presented");

    // Reporting a result clears the latched error.
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.emit |=> !bk_stat.err_set)
        else $error("error not cleared after result");
`endif

endmodule
